FILE: rtl/imsu_pkg.sv
// ----------------------------------------------------------------------------
// Ising Metropolis spin update: shared package
// Field widths, register indices and the command and status types passed
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package imsu_pkg;

  localparam int SIDE_DEFAULT = 64;

  localparam int SITE_W      = 12;
  localparam int FRAC_W      = 24;
  localparam int MAG_W       = 14;
  localparam int CFG_IDX_W   = 1;
  localparam int RECIP_SHIFT = 24;

  localparam logic [CFG_IDX_W-1:0] REG_THR_TWO  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_FOUR = 1'b1;

  typedef enum logic [2:0] {
    ADDR_OWN,
    ADDR_UP,
    ADDR_DOWN,
    ADDR_LEFT,
    ADDR_RIGHT
  } addr_sel_e;

  typedef struct packed {
    logic      load;
    logic      rd_en;
    addr_sel_e rd_sel;
    logic      acc_own;
    logic      acc_nbr;
    logic      commit;
    logic      clr_wr;
  } cmd_t;

  typedef struct packed {
    logic oor;
    logic clr_last;
  } status_t;

endpackage

FILE: rtl/ising_metropolis_spin_update_top.sv
// ----------------------------------------------------------------------------
// Ising Metropolis spin update: top level
// Single-spin Metropolis update on a periodic square lattice of spins with a
// running magnetization and two programmable acceptance thresholds.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_ready_o  site_i, uniform_draw_i
//   out      output     out_valid_o/out_ready_i  flipped_o, new_spin_o,
//                                                magnetization_o
//   cfg      input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// An item in the lattice is handled by five reads of the single-ported spin memory
// followed by the decision and write-back. The next item is accepted only
// after the decision, so the block does not take a new item before it is
// through with the last. A site outside the lattice skips the neighbour
// reads and goes from the own read straight to the decision.
// After reset a clearing pass sets every spin to +1, during which no item
// is accepted.
// A new item is accepted while the previous result waits; the decision stalls
// only if that result has still not been taken.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update_top #(
  parameter int SIDE = imsu_pkg::SIDE_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [imsu_pkg::SITE_W-1:0]         site_i,
  input  logic [imsu_pkg::FRAC_W-1:0]         uniform_draw_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                flipped_o,
  output logic                                new_spin_o,
  output logic signed [imsu_pkg::MAG_W-1:0]   magnetization_o,
  input  logic                                cfg_we_i,
  input  logic [imsu_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [imsu_pkg::FRAC_W-1:0]         cfg_wdata_i
);
  import imsu_pkg::*;

  cmd_t    cmd;
  status_t status;

  imsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  imsu_datapath #(
    .SIDE (SIDE)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .site_i          (site_i),
    .uniform_draw_i  (uniform_draw_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .flipped_o       (flipped_o),
    .new_spin_o      (new_spin_o),
    .magnetization_o (magnetization_o)
  );

endmodule

FILE: rtl/imsu_datapath.sv
// ----------------------------------------------------------------------------
// Ising Metropolis spin update: datapath
// Spin memory, neighbour address generation, neighbour count, acceptance
// decision, running magnetization, threshold registers and result register.
// ----------------------------------------------------------------------------
module imsu_datapath #(
  parameter int SIDE = imsu_pkg::SIDE_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  imsu_pkg::cmd_t                      cmd_i,
  output imsu_pkg::status_t                   status_o,
  input  logic [imsu_pkg::SITE_W-1:0]         site_i,
  input  logic [imsu_pkg::FRAC_W-1:0]         uniform_draw_i,
  input  logic                                cfg_we_i,
  input  logic [imsu_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [imsu_pkg::FRAC_W-1:0]         cfg_wdata_i,
  output logic                                flipped_o,
  output logic                                new_spin_o,
  output logic signed [imsu_pkg::MAG_W-1:0]   magnetization_o
);
  import imsu_pkg::*;

  localparam int NSITES = SIDE * SIDE;
  localparam int AW     = $clog2(NSITES);
  localparam int CW     = $clog2(SIDE);
  localparam int PROD_W = SITE_W + RECIP_SHIFT;
  localparam logic [RECIP_SHIFT-1:0] RECIP =
    RECIP_SHIFT'(((1 << RECIP_SHIFT) + SIDE - 1) / SIDE);

  logic                    mem_q [NSITES];
  logic                    rdata_q;
  logic [AW-1:0]           site_q;
  logic [FRAC_W-1:0]       draw_q;
  logic [CW-1:0]           row_q;
  logic [CW-1:0]           col_q;
  logic                    oor_q;
  logic                    own_q;
  logic [2:0]              count_q;
  logic [AW-1:0]           clr_addr_q;
  logic [FRAC_W-1:0]       thr_two_q;
  logic [FRAC_W-1:0]       thr_four_q;
  logic signed [MAG_W-1:0] total_q;
  logic                    flipped_q;
  logic                    new_spin_q;
  logic signed [MAG_W-1:0] mag_q;

  logic [PROD_W-1:0]       row_prod;
  logic [AW-1:0]           row_base;
  logic [AW-1:0]           up_addr;
  logic [AW-1:0]           down_addr;
  logic [AW-1:0]           left_addr;
  logic [AW-1:0]           right_addr;
  logic [AW-1:0]           rd_addr;
  logic [2:0]              ups;
  logic [2:0]              agree;
  logic                    flip;
  logic                    new_spin;
  logic signed [MAG_W-1:0] total_d;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic                    mem_wdata;

  assign row_prod = {RECIP_SHIFT'(0), site_i} * {SITE_W'(0), RECIP};
  assign row_base = AW'(row_q) * AW'(SIDE);

  assign up_addr    = (site_q < AW'(SIDE)) ? site_q + AW'(NSITES - SIDE)
                                           : site_q - AW'(SIDE);
  assign down_addr  = (site_q >= AW'(NSITES - SIDE)) ? site_q - AW'(NSITES - SIDE)
                                                     : site_q + AW'(SIDE);
  assign left_addr  = (col_q == CW'(0)) ? site_q + AW'(SIDE - 1)
                                        : site_q - AW'(1);
  assign right_addr = (col_q == CW'(SIDE - 1)) ? site_q - AW'(SIDE - 1)
                                               : site_q + AW'(1);

  always_comb begin
    unique case (cmd_i.rd_sel)
      ADDR_OWN:   rd_addr = site_q;
      ADDR_UP:    rd_addr = up_addr;
      ADDR_DOWN:  rd_addr = down_addr;
      ADDR_LEFT:  rd_addr = left_addr;
      ADDR_RIGHT: rd_addr = right_addr;
      default:    rd_addr = site_q;
    endcase
  end

  // The last neighbour read is still in the read register when deciding.
  assign ups   = count_q + {2'b00, rdata_q};
  assign agree = own_q ? ups : 3'd4 - ups;

  always_comb begin
    if (oor_q) begin
      flip = 1'b0;
    end else if (agree <= 3'd2) begin
      flip = 1'b1;
    end else if (agree == 3'd3) begin
      flip = draw_q < thr_two_q;
    end else begin
      flip = draw_q < thr_four_q;
    end
  end

  assign new_spin = oor_q ? 1'b0 : own_q ^ flip;
  assign total_d  = !flip ? total_q
                  : own_q ? total_q - MAG_W'(2) : total_q + MAG_W'(2);

  assign mem_we    = cmd_i.clr_wr | (cmd_i.commit & flip);
  assign mem_waddr = cmd_i.clr_wr ? clr_addr_q : site_q;
  assign mem_wdata = cmd_i.clr_wr | new_spin;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      site_q <= AW'(site_i);
      draw_q <= uniform_draw_i;
      row_q  <= CW'(row_prod[PROD_W-1 -: SITE_W]);
      oor_q  <= 17'(site_i) >= 17'(NSITES);
    end
    col_q <= CW'(site_q - row_base);
    if (cmd_i.acc_own) begin
      own_q <= rdata_q;
    end
    if (cmd_i.load) begin
      count_q <= 3'd0;
    end else if (cmd_i.acc_nbr) begin
      count_q <= count_q + {2'b00, rdata_q};
    end
    if (cmd_i.commit) begin
      flipped_q  <= flip;
      new_spin_q <= new_spin;
      mag_q      <= total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      thr_two_q  <= '0;
      thr_four_q <= '0;
      total_q    <= MAG_W'(NSITES);
    end else begin
      if (cmd_i.clr_wr) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_THR_TWO) begin
          thr_two_q <= cfg_wdata_i;
        end else if (cfg_idx_i == REG_THR_FOUR) begin
          thr_four_q <= cfg_wdata_i;
        end
      end
      if (cmd_i.commit) begin
        total_q <= total_d;
      end
    end
  end

  assign status_o.oor      = oor_q;
  assign status_o.clr_last = clr_addr_q == AW'(NSITES - 1);

  assign flipped_o       = flipped_q;
  assign new_spin_o      = new_spin_q;
  assign magnetization_o = mag_q;

endmodule

FILE: rtl/imsu_ctrl.sv
// ----------------------------------------------------------------------------
// Ising Metropolis spin update: controller
// Sequences the clearing pass, the lattice reads of each item (five inside the
// lattice, one outside), the decision with write-back and the result handshake.
// ----------------------------------------------------------------------------
module imsu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output imsu_pkg::cmd_t      cmd_o,
  input  imsu_pkg::status_t   status_i
);
  import imsu_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_OWN,
    ST_RD_UP,
    ST_RD_DOWN,
    ST_RD_LEFT,
    ST_RD_RIGHT,
    ST_DECIDE
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   slot_free;
  logic   commit;

  assign slot_free = !out_valid_q || out_ready_i;
  assign commit    = (state_q == ST_DECIDE) && slot_free;

  always_comb begin
    cmd_o         = '0;
    cmd_o.rd_sel  = ADDR_OWN;
    cmd_o.load    = in_ready_q && in_valid_i;
    cmd_o.commit  = commit;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
      end
      ST_IDLE: begin
      end
      ST_RD_OWN: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ADDR_OWN;
      end
      ST_RD_UP: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = ADDR_UP;
        cmd_o.acc_own = 1'b1;
      end
      ST_RD_DOWN: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = ADDR_DOWN;
        cmd_o.acc_nbr = 1'b1;
      end
      ST_RD_LEFT: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = ADDR_LEFT;
        cmd_o.acc_nbr = 1'b1;
      end
      ST_RD_RIGHT: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = ADDR_RIGHT;
        cmd_o.acc_nbr = 1'b1;
      end
      ST_DECIDE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      in_ready_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (status_i.clr_last) begin
            state_q    <= ST_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q    <= ST_RD_OWN;
            in_ready_q <= 1'b0;
          end
        end
        ST_RD_OWN: begin
          state_q <= status_i.oor ? ST_DECIDE : ST_RD_UP;
        end
        ST_RD_UP: begin
          state_q <= ST_RD_DOWN;
        end
        ST_RD_DOWN: begin
          state_q <= ST_RD_LEFT;
        end
        ST_RD_LEFT: begin
          state_q <= ST_RD_RIGHT;
        end
        ST_RD_RIGHT: begin
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (slot_free) begin
            state_q    <= ST_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

FILE: verif/ising_metropolis_spin_update_checker.sv
// ----------------------------------------------------------------------------
// Ising Metropolis spin update: result checker
// Watches the input, output and register write ports of the block. It keeps
// its own copy of the spin lattice, the running magnetization and both
// acceptance thresholds, works out the update for every accepted item and
// compares each returned item field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update_checker #(
  parameter int SIDE = imsu_pkg::SIDE_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [imsu_pkg::SITE_W-1:0]       site_i,
  input  logic [imsu_pkg::FRAC_W-1:0]       uniform_draw_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic                              flipped_i,
  input  logic                              new_spin_i,
  input  logic signed [imsu_pkg::MAG_W-1:0] magnetization_i,
  input  logic                              cfg_we_i,
  input  logic [imsu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [imsu_pkg::FRAC_W-1:0]       cfg_wdata_i,
  output int                                mismatches_o,
  output int                                outstanding_o
);
  import imsu_pkg::*;

  localparam int NSITES = SIDE * SIDE;

  typedef struct packed {
    logic [SITE_W-1:0]       site;
    logic                    flipped;
    logic                    new_spin;
    logic signed [MAG_W-1:0] magnetization;
  } spin_result_t;

  logic              spins [NSITES];
  int                spin_sum;
  logic [FRAC_W-1:0] thr_two;
  logic [FRAC_W-1:0] thr_four;
  spin_result_t      expected_updates [$];

  function automatic spin_result_t metropolis_update(input logic [SITE_W-1:0] site,
                                                     input logic [FRAC_W-1:0] draw);
    spin_result_t upd;
    int row;
    int col;
    int ups;
    int nsum;
    int prod;
    logic own;
    logic flip;
    upd.site = site;
    if (int'(site) >= NSITES) begin
      upd.flipped       = 1'b0;
      upd.new_spin      = 1'b0;
      upd.magnetization = spin_sum[MAG_W-1:0];
      return upd;
    end
    row  = int'(site) / SIDE;
    col  = int'(site) % SIDE;
    ups  = int'(spins[row * SIDE + (col + 1) % SIDE])
         + int'(spins[row * SIDE + (col + SIDE - 1) % SIDE])
         + int'(spins[((row + 1) % SIDE) * SIDE + col])
         + int'(spins[((row + SIDE - 1) % SIDE) * SIDE + col]);
    nsum = 2 * ups - 4;
    own  = spins[site];
    prod = own ? nsum : -nsum;
    if (prod <= 0) begin
      flip = 1'b1;
    end else if (prod == 2) begin
      flip = draw < thr_two;
    end else begin
      flip = draw < thr_four;
    end
    if (flip) begin
      spin_sum    = spin_sum + (own ? -2 : 2);
      own         = ~own;
      spins[site] = own;
    end
    upd.flipped       = flip;
    upd.new_spin      = own;
    upd.magnetization = spin_sum[MAG_W-1:0];
    return upd;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    spin_result_t exp_upd;
    int errs;
    if (!rst_ni) begin
      for (int i = 0; i < NSITES; i++) begin
        spins[i] = 1'b1;
      end
      spin_sum = NSITES;
      thr_two  = '0;
      thr_four = '0;
      expected_updates.delete();
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      errs = 0;
      if (out_valid_i && out_ready_i) begin
        if (expected_updates.size() == 0) begin
          $display("%0t: unexpected item: flipped %0b new_spin %0b magnetization %0d",
                   $time, flipped_i, new_spin_i, magnetization_i);
          errs++;
        end else begin
          exp_upd = expected_updates.pop_front();
          if (flipped_i !== exp_upd.flipped) begin
            $display("%0t: site %0d flipped expected %0b actual %0b",
                     $time, exp_upd.site, exp_upd.flipped, flipped_i);
            errs++;
          end
          if (new_spin_i !== exp_upd.new_spin) begin
            $display("%0t: site %0d new_spin expected %0b actual %0b",
                     $time, exp_upd.site, exp_upd.new_spin, new_spin_i);
            errs++;
          end
          if (magnetization_i !== exp_upd.magnetization) begin
            $display("%0t: site %0d magnetization expected %0d actual %0d",
                     $time, exp_upd.site, exp_upd.magnetization, magnetization_i);
            errs++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_THR_TWO: begin
            thr_two = cfg_wdata_i;
          end
          REG_THR_FOUR: begin
            thr_four = cfg_wdata_i;
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_updates.insert(expected_updates.size(),
                                metropolis_update(site_i, uniform_draw_i));
      end
      mismatches_o  <= mismatches_o + errs;
      outstanding_o <= expected_updates.size();
    end
  end

endmodule

FILE: verif/ising_metropolis_spin_update_top_tb.sv
// ----------------------------------------------------------------------------
// Ising Metropolis spin update: testbench top
// Drives directed and random site updates into the block under a range of
// acceptance thresholds, with bursty input and a stalling receiver, and
// leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update_top_tb;
  import imsu_pkg::*;

  localparam int SIDE            = SIDE_DEFAULT;
  localparam int NSITES          = SIDE * SIDE;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int SETTLE_CYCLES   = 16;
  localparam int IDLE_LIMIT      = 20000;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_valid   = 1'b0;
  logic                    in_ready;
  logic [SITE_W-1:0]       site       = '0;
  logic [FRAC_W-1:0]       draw       = '0;
  logic                    out_valid;
  logic                    out_ready  = 1'b0;
  logic                    flipped;
  logic                    new_spin;
  logic signed [MAG_W-1:0] magnetization;
  logic                    cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx    = '0;
  logic [FRAC_W-1:0]       cfg_wdata  = '0;
  int                      mismatches;
  int                      outstanding;

  logic              stall_mode  = 1'b0;
  int                ready_run   = 0;
  int                idle_cycles = 0;
  logic              bursty      = 1'b0;
  int                burst_left  = 0;
  logic [FRAC_W-1:0] cur_two     = '0;
  logic [FRAC_W-1:0] cur_four    = '0;

  always #5 clk = ~clk;

  ising_metropolis_spin_update_top #(
    .SIDE(SIDE)
  ) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .site_i         (site),
    .uniform_draw_i (draw),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .flipped_o      (flipped),
    .new_spin_o     (new_spin),
    .magnetization_o(magnetization),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  ising_metropolis_spin_update_checker #(
    .SIDE(SIDE)
  ) u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .site_i         (site),
    .uniform_draw_i (draw),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .flipped_i      (flipped),
    .new_spin_i     (new_spin),
    .magnetization_i(magnetization),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding)
  );

  always @(posedge clk) begin
    if (!stall_mode) begin
      out_ready <= 1'b1;
    end else if (ready_run > 0) begin
      ready_run <= ready_run - 1;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      ready_run <= $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
      ready_run <= $urandom_range(0, 7);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("ising_metropolis_spin_update_top regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_spin_update(input logic [SITE_W-1:0] s, input logic [FRAC_W-1:0] d);
    int gap;
    if (bursty && burst_left == 0) begin
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    site     <= s;
    draw     <= d;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  task automatic drain_updates();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [FRAC_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_THR_TWO) begin
      cur_two = value;
    end else begin
      cur_four = value;
    end
  endtask

  // Most sites fall in a small patch across the corner, so that neighbours
  // interact and the wrap-around borders are crossed often.
  function automatic logic [SITE_W-1:0] pick_site();
    int r;
    int row;
    int col;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      row = (SIDE - 2 + $urandom_range(0, 4)) % SIDE;
      col = (SIDE - 2 + $urandom_range(0, 4)) % SIDE;
      return SITE_W'(row * SIDE + col);
    end else if (r < 90) begin
      return SITE_W'($urandom_range(0, NSITES - 1));
    end
    return r[0] ? SITE_W'(0) : SITE_W'(NSITES - 1);
  endfunction

  function automatic logic [FRAC_W-1:0] pick_draw();
    int r;
    logic [FRAC_W-1:0] base;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return FRAC_W'($urandom());
    end else if (r < 80) begin
      base = r[0] ? cur_two : cur_four;
      return base + FRAC_W'($urandom_range(0, 2)) - FRAC_W'(1);
    end
    return r[0] ? '0 : '1;
  endfunction

  initial begin
    logic [FRAC_W-1:0] two;
    logic [FRAC_W-1:0] four;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // With both thresholds at zero a fully aligned site never flips.
    send_spin_update(SITE_W'(0), '0);
    send_spin_update(SITE_W'(NSITES - 1), '1);
    drain_updates();

    write_threshold(REG_THR_TWO, '1);
    write_threshold(REG_THR_FOUR, FRAC_W'(1));
    send_spin_update(SITE_W'(0), '0);
    send_spin_update(SITE_W'(1), '1);
    send_spin_update(SITE_W'(1), FRAC_W'(24'hFFFFFE));
    send_spin_update(SITE_W'(0), '1);
    send_spin_update(SITE_W'(SIDE), '0);
    send_spin_update(SITE_W'(SIDE + 1), '1);
    send_spin_update(SITE_W'(NSITES - 1), FRAC_W'(1));
    send_spin_update(SITE_W'(NSITES - 1), '0);
    send_spin_update(SITE_W'(0), FRAC_W'(1));
    send_spin_update(SITE_W'(SIDE - 1), '0);
    send_spin_update(SITE_W'(NSITES - SIDE), FRAC_W'(24'h800000));

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_updates();
      case (p)
        0: begin
          two  = '0;
          four = '0;
        end
        1: begin
          two  = '1;
          four = '1;
        end
        2: begin
          two  = '0;
          four = '1;
        end
        default: begin
          two  = FRAC_W'($urandom());
          four = FRAC_W'($urandom());
        end
      endcase
      write_threshold(REG_THR_TWO, two);
      write_threshold(REG_THR_FOUR, four);
      bursty     = p[0];
      stall_mode <= p[1];
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_spin_update(pick_site(), pick_draw());
      end
    end

    drain_updates();
    if (mismatches == 0) begin
      $display("ising_metropolis_spin_update_top regression: pass");
    end else begin
      $display("ising_metropolis_spin_update_top regression: fail");
    end
    $finish;
  end

endmodule
